### rtl/core/tccw_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the text console cell writer: screen geometry defaults,
// operation codes, blank cell and stream field layout. No dependencies.
package tccw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 30;

    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = CHAR_W + ATTR_W;
    localparam int COL_FIELD_W = 7;
    localparam int ROW_FIELD_W = 5;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [OP_W-1:0] OP_PUT       = 2'd0;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

    localparam int CURSOR_ROW_RESET = 3;

endpackage

### rtl/core/text_console_cell_writer_unit.sv
`timescale 1ns / 1ps
// Text console cell writer: screen store in one synchronous RAM, cursor,
// circular row base for scrolling. Depends on tccw_pkg.
//
// Flow: an accepted transaction goes to the emit state, which registers its result on
// m_tvalid once the output is free; a put that scrolls first passes through the scroll
// state for the blanking sweep of the new bottom row. The single RAM port pair and the
// one-item-at-a-time sequencer take no new item until the last result is registered.
// Reset: cursor goes to column 0, row 3, attribute to 0x0F; a clearing pass then
// writes blanks to all COLUMNS*ROWS cells, s_tready low.
module text_console_cell_writer_unit #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tccw_pkg::ATTR_W-1:0]     cfg_wr_data,    // text_attribute
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tccw_pkg::S_TDATA_W-1:0]  s_tdata,   // char_code, read_column, read_row
    input  logic [tccw_pkg::OP_W-1:0]       s_tuser,   // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cursor_column, cursor_row, cell_char, cell_attribute, scrolled
    output logic [tccw_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int DEPTH = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;

    // Logical row to RAM address through the circular row base.
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] lrow,
                                                 input logic [CW-1:0] col,
                                                 input logic [RW-1:0] base);
        logic [RW:0] prow;
        prow = {1'b0, lrow} + {1'b0, base};
        if (prow >= (RW+1)'(ROWS)) begin
            prow = prow - (RW+1)'(ROWS);
        end
        return AW'(int'(prow) * COLUMNS + int'(col));
    endfunction

    logic [tccw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tccw_pkg::CELL_W-1:0] rd_data_reg;

    logic [2:0]                   state_reg, state_next;
    logic [AW-1:0]                sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]                sweep_last_reg, sweep_last_next;
    logic [CW-1:0]                cur_col_reg, cur_col_next;
    logic [RW-1:0]                cur_row_reg, cur_row_next;
    logic [RW-1:0]                base_reg, base_next;
    logic [tccw_pkg::ATTR_W-1:0]  attr_reg, attr_next;
    logic                         res_read_reg, res_read_next;
    logic                         res_scroll_reg, res_scroll_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [tccw_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tccw_pkg::CELL_W-1:0]  mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;

    logic                         in_fire;
    logic                         out_free;
    logic [tccw_pkg::OP_W-1:0]    in_op;
    logic [tccw_pkg::CHAR_W-1:0]  in_char;
    logic [tccw_pkg::COL_FIELD_W-1:0] in_rcol;
    logic [tccw_pkg::ROW_FIELD_W-1:0] in_rrow;
    logic                         rd_in_range;
    logic                         col_wrap;
    logic                         row_last;
    logic [tccw_pkg::CHAR_W-1:0]  out_char;
    logic [tccw_pkg::ATTR_W-1:0]  out_attr;

    assign in_op   = s_tuser;
    assign in_char = s_tdata[7:0];
    assign in_rcol = s_tdata[14:8];
    assign in_rrow = s_tdata[19:15];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_in_range = (int'(in_rcol) < COLUMNS) && (int'(in_rrow) < ROWS);
    assign col_wrap    = (cur_col_reg == CW'(COLUMNS - 1)) || (in_char == tccw_pkg::NEWLINE_CODE);
    assign row_last    = (cur_row_reg == RW'(ROWS - 1));

    assign out_char = res_read_reg ? rd_data_reg[7:0]  : '0;
    assign out_attr = res_read_reg ? rd_data_reg[15:8] : '0;

    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        base_next       = base_reg;
        attr_next       = cfg_wr_en ? cfg_wr_data : attr_reg;
        res_read_next   = res_read_reg;
        res_scroll_next = res_scroll_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = tccw_pkg::BLANK_CELL;
        mem_re          = 1'b0;
        mem_raddr       = cell_addr(RW'(in_rrow), CW'(in_rcol), base_reg);

        unique case (state_reg) inside
            ST_CLEAR, ST_SCROLL: begin
                mem_we          = 1'b1;
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (sweep_addr_reg == sweep_last_reg) begin
                    state_next = (state_reg == ST_CLEAR) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    res_read_next   = 1'b0;
                    res_scroll_next = 1'b0;
                    state_next      = ST_EMIT;
                    unique case (in_op)
                        tccw_pkg::OP_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(cur_row_reg, cur_col_reg, base_reg);
                            mem_wdata = {attr_reg, in_char};
                            cur_col_next = col_wrap ? '0 : cur_col_reg + CW'(1);
                            if (col_wrap && !row_last) begin
                                cur_row_next = cur_row_reg + RW'(1);
                            end
                            if (col_wrap && row_last) begin
                                // advance the row base; old top row becomes the blank bottom
                                res_scroll_next = 1'b1;
                                state_next      = ST_SCROLL;
                                base_next       = (base_reg == RW'(ROWS - 1)) ? '0
                                                                             : base_reg + RW'(1);
                                sweep_addr_next = AW'(int'(base_reg) * COLUMNS);
                                sweep_last_next = AW'(int'(base_reg) * COLUMNS + COLUMNS - 1);
                            end
                        end
                        tccw_pkg::OP_BACKSPACE: begin
                            if (cur_col_reg != '0) begin
                                cur_col_next = cur_col_reg - CW'(1);
                                mem_we       = 1'b1;
                                mem_waddr    = cell_addr(cur_row_reg, cur_col_reg - CW'(1),
                                                         base_reg);
                                mem_wdata    = {attr_reg, tccw_pkg::SPACE_CODE};
                            end
                        end
                        tccw_pkg::OP_READ: begin
                            mem_re        = rd_in_range;
                            res_read_next = rd_in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_scroll_reg, out_attr, out_char,
                                     5'(cur_row_reg), 7'(cur_col_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            sweep_addr_reg <= '0;
            sweep_last_reg <= AW'(DEPTH - 1);
            cur_col_reg    <= '0;
            cur_row_reg    <= RW'(tccw_pkg::CURSOR_ROW_RESET);
            base_reg       <= '0;
            attr_reg       <= tccw_pkg::ATTR_RESET;
            res_read_reg   <= 1'b0;
            res_scroll_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            base_reg       <= base_next;
            attr_reg       <= attr_next;
            res_read_reg   <= res_read_next;
            res_scroll_reg <= res_scroll_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // Screen store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("screen store read and write in the same cycle");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(cur_col_reg) < COLUMNS) && (int'(cur_row_reg) < ROWS))
        else $error("cursor outside the screen");

    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(base_reg) < ROWS)
        else $error("row base outside the screen");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken before the first finished");

    a_result_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("result shown outside the emit step");

endmodule

### sim/text_console_cell_writer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_cell_writer_unit. It streams put, backspace,
// read and reserved commands, tracks cursor, screen cells and scrolling in its own
// model, and compares every result. Depends on tccw_pkg and the unit only.
module text_console_cell_writer_unit_test;

    localparam int COLS = tccw_pkg::COLUMNS_DEFAULT;
    localparam int ROWS = tccw_pkg::ROWS_DEFAULT;
    localparam logic [tccw_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int PHASE_ITEMS  = 600;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = COLS + 10;

    typedef struct packed {
        logic [tccw_pkg::OP_W-1:0]        op;
        logic [tccw_pkg::CHAR_W-1:0]      char_code;
        logic [tccw_pkg::COL_FIELD_W-1:0] read_col;
        logic [tccw_pkg::ROW_FIELD_W-1:0] read_row;
    } console_cmd_t;

    typedef struct packed {
        logic [tccw_pkg::COL_FIELD_W-1:0] cursor_col;
        logic [tccw_pkg::ROW_FIELD_W-1:0] cursor_row;
        logic [tccw_pkg::CHAR_W-1:0]      cell_char;
        logic [tccw_pkg::ATTR_W-1:0]      cell_attr;
        logic                             scrolled;
    } console_report_t;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [tccw_pkg::ATTR_W-1:0]      cfg_wr_data = '0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [tccw_pkg::S_TDATA_W-1:0]   s_tdata     = '0;   // char_code, read_column, read_row
    logic [tccw_pkg::OP_W-1:0]        s_tuser     = '0;   // operation
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    // cursor_column, cursor_row, cell_char, cell_attribute, scrolled
    logic [tccw_pkg::M_TDATA_W-1:0]   m_tdata;

    // screen model and cursor
    logic [tccw_pkg::CELL_W-1:0] screen_model [COLS*ROWS];
    int                          cur_col;
    int                          cur_row;
    logic [tccw_pkg::ATTR_W-1:0] text_attr;

    console_cmd_t    cmd_queue[$];
    console_report_t expected_reports[$];

    bit s_taken = 1'b0;
    int send_idle_pct = 38;
    int recv_idle_pct = 80;
    int stall_cycles = 0;
    int mismatches = 0;
    int n_results = 0;
    int n_puts = 0, n_backspaces = 0, n_reads = 0, n_reserved = 0, n_scrolls = 0;

    text_console_cell_writer_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic console_report_t apply_console_cmd(console_cmd_t cmd);
        console_report_t rep;
        int addr;
        rep = '0;
        case (cmd.op)
            tccw_pkg::OP_PUT: begin
                n_puts++;
                screen_model[cur_row*COLS + cur_col] = {text_attr, cmd.char_code};
                cur_col++;
                if (cur_col >= COLS || cmd.char_code == tccw_pkg::NEWLINE_CODE) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    // shift rows up, bottom row always blank with the default attribute
                    for (addr = 0; addr < COLS*(ROWS-1); addr++)
                        screen_model[addr] = screen_model[addr + COLS];
                    for (addr = COLS*(ROWS-1); addr < COLS*ROWS; addr++)
                        screen_model[addr] = tccw_pkg::BLANK_CELL;
                    cur_row = ROWS - 1;
                    rep.scrolled = 1'b1;
                    n_scrolls++;
                end
            end
            tccw_pkg::OP_BACKSPACE: begin
                n_backspaces++;
                if (cur_col != 0) begin
                    cur_col--;
                    screen_model[cur_row*COLS + cur_col] = {text_attr, tccw_pkg::SPACE_CODE};
                end
            end
            tccw_pkg::OP_READ: begin
                n_reads++;
                if (int'(cmd.read_col) < COLS && int'(cmd.read_row) < ROWS)
                    {rep.cell_attr, rep.cell_char} =
                        screen_model[int'(cmd.read_row)*COLS + int'(cmd.read_col)];
            end
            default: n_reserved++;
        endcase
        rep.cursor_col = cur_col[tccw_pkg::COL_FIELD_W-1:0];
        rep.cursor_row = cur_row[tccw_pkg::ROW_FIELD_W-1:0];
        return rep;
    endfunction

    function automatic console_cmd_t rand_console_cmd();
        console_cmd_t c;
        int pick;
        c.op        = tccw_pkg::OP_PUT;
        c.char_code = tccw_pkg::CHAR_W'($urandom_range(255));
        c.read_col  = tccw_pkg::COL_FIELD_W'($urandom_range(127));
        c.read_row  = tccw_pkg::ROW_FIELD_W'($urandom_range(31));
        pick = int'($urandom_range(99));
        if (pick < 58) begin
            // frequent newlines walk the cursor down so the screen scrolls often
            if ($urandom_range(7) == 0)
                c.char_code = tccw_pkg::NEWLINE_CODE;
        end else if (pick < 70) begin
            c.op = tccw_pkg::OP_BACKSPACE;
        end else if (pick < 95) begin
            c.op = tccw_pkg::OP_READ;
            if ($urandom_range(4) != 0) begin
                c.read_col = tccw_pkg::COL_FIELD_W'($urandom_range(COLS - 1));
                // bias toward the bottom rows, where the writes land
                if ($urandom_range(1) != 0)
                    c.read_row = tccw_pkg::ROW_FIELD_W'($urandom_range(ROWS - 1));
                else
                    c.read_row = tccw_pkg::ROW_FIELD_W'($urandom_range(ROWS - 1, ROWS - 5));
            end
        end else begin
            c.op = OP_RESERVED;
        end
        return c;
    endfunction

    task automatic write_text_attr(input logic [tccw_pkg::ATTR_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        text_attr = value;
    endtask

    task automatic drain_results();
        while (cmd_queue.size() != 0 || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // drive inputs on the falling edge; hold a presented transaction until taken
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (s_tvalid && !s_taken) begin
            // hold
        end else if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata  <= {{(tccw_pkg::S_TDATA_W-20){1'b0}}, cmd_queue[0].read_row,
                         cmd_queue[0].read_col, cmd_queue[0].char_code};
            s_tuser  <= cmd_queue[0].op;
        end else begin
            s_tvalid <= 1'b0;
        end
        s_taken = 1'b0;
    end

    always @(posedge aclk) begin
        console_cmd_t cmd;
        if (aresetn && s_tvalid && s_tready) begin
            cmd.op        = s_tuser;
            cmd.char_code = s_tdata[7:0];
            cmd.read_col  = s_tdata[14:8];
            cmd.read_row  = s_tdata[19:15];
            expected_reports.push_back(apply_console_cmd(cmd));
            void'(cmd_queue.pop_front());
            s_taken = 1'b1;
        end
    end

    always @(posedge aclk) begin
        console_report_t got;
        console_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            got = {m_tdata[6:0], m_tdata[11:7], m_tdata[19:12], m_tdata[27:20], m_tdata[28]};
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: col %0d row %0d char %02h attr %02h scroll %0b",
                             got.cursor_col, got.cursor_row, got.cell_char, got.cell_attr,
                             got.scrolled);
            end else begin
                want = expected_reports.pop_front();
                if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row
                    || got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr
                    || got.scrolled !== want.scrolled) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: expected col %0d row %0d char %02h %s",
                                 n_results, want.cursor_col, want.cursor_row, want.cell_char,
                                 $sformatf("attr %02h scroll %0b; actual col %0d row %0d %s",
                                           want.cell_attr, want.scrolled, got.cursor_col,
                                           got.cursor_row,
                                           $sformatf("char %02h attr %02h scroll %0b",
                                                     got.cell_char, got.cell_attr,
                                                     got.scrolled)));
                end
            end
        end
    end

    // end the run when nothing moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("text_console_cell_writer_unit regression: fail");
            $finish;
        end
    end

    initial begin
        int idx;
        int phase;
        for (idx = 0; idx < COLS*ROWS; idx++)
            screen_model[idx] = tccw_pkg::BLANK_CELL;
        cur_col   = 0;
        cur_row   = tccw_pkg::CURSOR_ROW_RESET;
        text_attr = tccw_pkg::ATTR_RESET;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset contents, out-of-screen reads, reserved code, backspace edges
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'(COLS-1), 5'(ROWS-1)});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'hFF, 7'd127, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd31});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'(COLS), 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'd0, 5'(ROWS)});
        cmd_queue.push_back(console_cmd_t'{OP_RESERVED, 8'hFF, 7'd127, 5'd31});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_BACKSPACE, 8'hFF, 7'd127, 5'd31});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_PUT, 8'h00, 7'd0, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_PUT, 8'hFF, 7'd0, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd3});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'd1, 5'd3});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_BACKSPACE, 8'h00, 7'd0, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'd1, 5'd3});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE,
                                           7'd0, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'd1, 5'd3});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_PUT, 8'h41, 7'd0, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_BACKSPACE, 8'h00, 7'd0, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_BACKSPACE, 8'h00, 7'd0, 5'd0});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd4});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_PUT, 8'h7E, 7'd127, 5'd31});
        cmd_queue.push_back(console_cmd_t'{tccw_pkg::OP_READ, 8'hFF, 7'd0, 5'd4});
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: write_text_attr(8'h00);
                1: write_text_attr(8'hFF);
                default: write_text_attr(tccw_pkg::ATTR_W'($urandom_range(255)));
            endcase
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 38 : 0;
            for (idx = 0; idx < PHASE_ITEMS; idx++)
                cmd_queue.push_back(rand_console_cmd());
            drain_results();
        end

        $display("covered %0d puts, %0d backspaces, %0d reads, %0d reserved codes, %0d scrolls",
                 n_puts, n_backspaces, n_reads, n_reserved, n_scrolls);
        $display("checked %0d results, %0d mismatches", n_results, mismatches);
        if (mismatches == 0) begin
            $display("text_console_cell_writer_unit regression: pass");
        end else begin
            $display("text_console_cell_writer_unit regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/tccw_pkg.sv
rtl/core/text_console_cell_writer_unit.sv
sim/text_console_cell_writer_unit_test.sv
